/* design/dcf_pkg.sv */
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// dcf_pkg: shared types and codes of the directed cycle finder
// Request and result layouts, action and status codes, default sizes.
// ----------------------------------------------------------------------------
package dcf_pkg;

	localparam int DEF_MAX_VERTICES = 32;
	localparam int DEF_MAX_EDGES    = 256;

	localparam logic [5:0] VCOUNT_RESET = 6'd32;

	localparam logic [1:0] ACT_ADD   = 2'd0;
	localparam logic [1:0] ACT_RUN   = 2'd1;
	localparam logic [1:0] ACT_CLEAR = 2'd2;

	localparam logic [1:0] ST_OK    = 2'd0;
	localparam logic [1:0] ST_FULL  = 2'd1;
	localparam logic [1:0] ST_RANGE = 2'd2;

	typedef struct packed {
		logic [1:0] action;
		logic [4:0] src_vertex;
		logic [4:0] dst_vertex;
	} req_t;

	typedef struct packed {
		logic [1:0] status;
		logic       has_cycle;
		logic [4:0] cycle_vertex;
		logic       last;
	} res_t;

endpackage
`default_nettype wire

/* design/dcf_ram.sv */
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// dcf_ram: generic simple dual-port RAM
// One write port, one read port with registered read data.
// ----------------------------------------------------------------------------
module dcf_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 256
) (
	input  wire logic                     clk,
	input  wire logic                     we,
	input  wire logic [$clog2(DEPTH)-1:0] waddr,
	input  wire logic [WIDTH-1:0]         wdata,
	input  wire logic [$clog2(DEPTH)-1:0] raddr,
	output      logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		rdata <= mem_q[raddr];
	end

endmodule
`default_nettype wire

/* design/dcf_engine.sv */
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// dcf_engine: edge store and depth-first search sequencer
// Keeps per-vertex edge lists in two RAMs, walks them with an explicit
// stack, and streams out the cycle found; no new request is taken while busy.
// ----------------------------------------------------------------------------
module dcf_engine
	import dcf_pkg::*;
#(
	parameter int MAX_VERTICES = DEF_MAX_VERTICES,
	parameter int MAX_EDGES    = DEF_MAX_EDGES
) (
	input  wire logic                              clk,
	input  wire logic                              arst_n,
	input  wire logic                              start,
	input  wire req_t                              req,
	input  wire logic [$clog2(MAX_VERTICES+1)-1:0] live_n,
	output      logic                              busy,
	output      logic                              res_valid,
	output      res_t                              res
);

	localparam int VW = $clog2(MAX_VERTICES);
	localparam int NW = $clog2(MAX_VERTICES + 1);
	localparam int AW = (MAX_EDGES > 1) ? $clog2(MAX_EDGES) : 1;
	localparam int LW = $clog2(MAX_EDGES + 1);
	localparam int RW = (MAX_EDGES > 1) ? MAX_EDGES : 2;
	localparam logic [LW-1:0] NO_EDGE = LW'(MAX_EDGES);

	typedef enum logic [6:0] {
		S_IDLE = 7'b0000001,
		S_LINK = 7'b0000010,
		S_ROOT = 7'b0000100,
		S_TOP  = 7'b0001000,
		S_EDGE = 7'b0010000,
		S_WALK = 7'b0100000,
		S_LAST = 7'b1000000
	} state_t;

	state_t            state_q;
	logic [NW-1:0]     root_q;
	logic [NW-1:0]     depth_q;
	logic [NW-1:0]     steps_q;
	logic [LW-1:0]     ecnt_q;
	logic [MAX_VERTICES-1:0] visited_q;
	logic [MAX_VERTICES-1:0] onpath_q;
	logic [MAX_VERTICES-1:0] lvld_q;
	logic [AW-1:0]     head_q [MAX_VERTICES];
	logic [AW-1:0]     tail_q [MAX_VERTICES];
	logic [VW-1:0]     wv_q   [MAX_VERTICES];
	logic [LW-1:0]     wc_q   [MAX_VERTICES];
	logic [VW-1:0]     came_q [MAX_VERTICES];
	logic [VW-1:0]     cs_q;
	logic [VW-1:0]     cw_q;
	logic [VW-1:0]     it_q;
	logic [AW-1:0]     link_addr_q;
	logic [LW-1:0]     link_dat_q;

	logic          accept;
	logic [VW-1:0] src_v;
	logic [VW-1:0] dst_v;
	logic          bad_vtx;
	logic          full;
	logic          add_ok;
	logic [1:0]    add_st;
	logic [VW-1:0] top;
	logic [VW-1:0] cur_v;
	logic [LW-1:0] cur_e;
	logic [VW-1:0] root_v;
	logic [VW-1:0] rd_tgt;
	logic [LW-1:0] rd_link;
	logic          w_out;
	logic          can_push;
	logic [VW-1:0] push_idx;
	logic          walk_more;

	logic          tgt_we;
	logic          link_we;
	logic [AW-1:0] link_waddr;
	logic [LW-1:0] link_wdata;

	assign accept   = start && (state_q == S_IDLE);
	assign busy     = (state_q != S_IDLE);
	assign src_v    = VW'(req.src_vertex);
	assign dst_v    = VW'(req.dst_vertex);
	assign bad_vtx  = ({1'b0, req.src_vertex} >= 6'(live_n))
	               || ({1'b0, req.dst_vertex} >= 6'(live_n));
	assign full     = (ecnt_q >= NO_EDGE);
	assign add_ok   = !bad_vtx && !full;
	assign add_st   = (req.action != ACT_ADD) ? ST_OK :
	                  bad_vtx ? ST_RANGE : (full ? ST_FULL : ST_OK);
	assign top      = VW'(depth_q - NW'(1));
	assign cur_v    = wv_q[top];
	assign cur_e    = wc_q[top];
	assign root_v   = VW'(root_q);
	assign w_out    = (NW'(rd_tgt) >= live_n);
	assign can_push = (depth_q < NW'(MAX_VERTICES));
	assign push_idx = VW'(depth_q);
	assign walk_more = (it_q != cw_q) && (steps_q < NW'(MAX_VERTICES));

	assign tgt_we     = accept && (req.action == ACT_ADD) && add_ok;
	assign link_we    = tgt_we || (state_q == S_LINK);
	assign link_waddr = (state_q == S_LINK) ? link_addr_q : ecnt_q[AW-1:0];
	assign link_wdata = (state_q == S_LINK) ? link_dat_q : NO_EDGE;

	dcf_ram #(.WIDTH(VW), .DEPTH(RW)) u_tgt_ram (
		.clk   (clk),
		.we    (tgt_we),
		.waddr (ecnt_q[AW-1:0]),
		.wdata (dst_v),
		.raddr (cur_e[AW-1:0]),
		.rdata (rd_tgt)
	);

	dcf_ram #(.WIDTH(LW), .DEPTH(RW)) u_link_ram (
		.clk   (clk),
		.we    (link_we),
		.waddr (link_waddr),
		.wdata (link_wdata),
		.raddr (cur_e[AW-1:0]),
		.rdata (rd_link)
	);

	// control state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q   <= S_IDLE;
			root_q    <= '0;
			depth_q   <= '0;
			steps_q   <= '0;
			ecnt_q    <= '0;
			visited_q <= '0;
			onpath_q  <= '0;
			lvld_q    <= '0;
			res_valid <= 1'b0;
		end else begin
			res_valid <= 1'b0;
			case (state_q)
				S_IDLE: begin
					if (accept) begin
						case (req.action)
							ACT_ADD: begin
								res_valid <= 1'b1;
								if (add_ok) begin
									ecnt_q         <= ecnt_q + LW'(1);
									lvld_q[src_v]  <= 1'b1;
									if (lvld_q[src_v]) begin
										state_q <= S_LINK;
									end
								end
							end
							ACT_RUN: begin
								visited_q <= '0;
								onpath_q  <= '0;
								root_q    <= '0;
								depth_q   <= '0;
								state_q   <= S_ROOT;
							end
							ACT_CLEAR: begin
								lvld_q    <= '0;
								ecnt_q    <= '0;
								res_valid <= 1'b1;
							end
							default: begin
								res_valid <= 1'b1;
							end
						endcase
					end
				end
				S_LINK: begin
					state_q <= S_IDLE;
				end
				S_ROOT: begin
					if (root_q >= live_n) begin
						res_valid <= 1'b1;
						state_q   <= S_IDLE;
					end else if (visited_q[root_v]) begin
						root_q <= root_q + NW'(1);
					end else begin
						visited_q[root_v] <= 1'b1;
						onpath_q[root_v]  <= 1'b1;
						depth_q           <= NW'(1);
						state_q           <= S_TOP;
					end
				end
				S_TOP: begin
					if (depth_q == '0) begin
						root_q  <= root_q + NW'(1);
						state_q <= S_ROOT;
					end else if (cur_e == NO_EDGE) begin
						onpath_q[cur_v] <= 1'b0;
						depth_q         <= depth_q - NW'(1);
					end else begin
						state_q <= S_EDGE;
					end
				end
				S_EDGE: begin
					state_q <= S_TOP;
					if (!w_out) begin
						if (!visited_q[rd_tgt]) begin
							visited_q[rd_tgt] <= 1'b1;
							onpath_q[rd_tgt]  <= 1'b1;
							if (can_push) begin
								depth_q <= depth_q + NW'(1);
							end
						end else if (onpath_q[rd_tgt]) begin
							steps_q <= '0;
							state_q <= S_WALK;
						end
					end
				end
				S_WALK: begin
					res_valid <= 1'b1;
					if (walk_more) begin
						steps_q <= steps_q + NW'(1);
					end else begin
						state_q <= S_LAST;
					end
				end
				S_LAST: begin
					res_valid <= 1'b1;
					state_q   <= S_IDLE;
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

	// payload
	always_ff @(posedge clk) begin
		case (state_q)
			S_IDLE: begin
				res <= '{status: add_st, has_cycle: 1'b0, cycle_vertex: 5'd0, last: 1'b1};
				if (accept && (req.action == ACT_ADD) && add_ok) begin
					tail_q[src_v] <= ecnt_q[AW-1:0];
					link_addr_q   <= tail_q[src_v];
					link_dat_q    <= ecnt_q;
					if (!lvld_q[src_v]) begin
						head_q[src_v] <= ecnt_q[AW-1:0];
					end
				end
			end
			S_ROOT: begin
				res <= '{status: ST_OK, has_cycle: 1'b0, cycle_vertex: 5'd0, last: 1'b1};
				if (root_q < live_n && !visited_q[root_v]) begin
					came_q[root_v] <= root_v;
					wv_q[0]        <= root_v;
					wc_q[0]        <= lvld_q[root_v] ? LW'(head_q[root_v]) : NO_EDGE;
				end
			end
			S_EDGE: begin
				wc_q[top] <= rd_link;
				if (!w_out) begin
					if (!visited_q[rd_tgt]) begin
						came_q[rd_tgt] <= cur_v;
						if (can_push) begin
							wv_q[push_idx] <= rd_tgt;
							wc_q[push_idx] <= lvld_q[rd_tgt] ? LW'(head_q[rd_tgt]) : NO_EDGE;
						end
					end else if (onpath_q[rd_tgt]) begin
						cs_q <= cur_v;
						cw_q <= rd_tgt;
						it_q <= cur_v;
					end
				end
			end
			S_WALK: begin
				res.status    <= ST_OK;
				res.has_cycle <= 1'b1;
				res.last      <= 1'b0;
				if (walk_more) begin
					res.cycle_vertex <= 5'(it_q);
					it_q             <= came_q[it_q];
				end else begin
					res.cycle_vertex <= 5'(cw_q);
				end
			end
			S_LAST: begin
				res.status       <= ST_OK;
				res.has_cycle    <= 1'b1;
				res.cycle_vertex <= 5'(cs_q);
				res.last         <= 1'b1;
			end
			default: begin
			end
		endcase
	end

endmodule
`default_nettype wire

/* design/directed_cycle_finder_top.sv */
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// directed_cycle_finder_top: directed cycle finder by depth-first search
// Loads edges, searches for a directed cycle, reports its vertices.
//
//   channel  signals                       transfer
//   request  start, busy, req              start && !busy
//   result   res_valid, res                res_valid
//   config   cfg_valid, cfg_ready, cfg_data cfg_valid && cfg_ready
//
// Add edge: appending to a non-empty list also passes a link-update state;
// result the cycle after the request. Clear and unused actions stay idle.
// Run: tries each root in turn; the search stack steps through the edge RAMs,
// each edge in a top and an edge state, then the cycle is reported per vertex.
// Reset empties the edge store; vertex count resets to 32.
// Results cannot be held off; cfg_ready is low while busy.
// ----------------------------------------------------------------------------
module directed_cycle_finder_top
	import dcf_pkg::*;
#(
	parameter int MAX_VERTICES = DEF_MAX_VERTICES,
	parameter int MAX_EDGES    = DEF_MAX_EDGES
) (
	input  wire logic       clk,
	input  wire logic       arst_n,
	input  wire logic       start,
	input  wire req_t       req,
	output      logic       busy,
	output      logic       res_valid,
	output      res_t       res,
	input  wire logic       cfg_valid,
	output      logic       cfg_ready,
	input  wire logic [5:0] cfg_data
);

	localparam int NW = $clog2(MAX_VERTICES + 1);

	logic [5:0]    vcount_q;
	logic [NW-1:0] live_n;

	assign cfg_ready = !busy;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vcount_q <= VCOUNT_RESET;
		end else if (cfg_valid && cfg_ready) begin
			vcount_q <= cfg_data;
		end
	end

	always_comb begin
		if (vcount_q == '0) begin
			live_n = NW'(1);
		end else if ({1'b0, vcount_q} > 7'(MAX_VERTICES)) begin
			live_n = NW'(MAX_VERTICES);
		end else begin
			live_n = NW'(vcount_q);
		end
	end

	dcf_engine #(
		.MAX_VERTICES (MAX_VERTICES),
		.MAX_EDGES    (MAX_EDGES)
	) u_engine (
		.clk       (clk),
		.arst_n    (arst_n),
		.start     (start),
		.req       (req),
		.live_n    (live_n),
		.busy      (busy),
		.res_valid (res_valid),
		.res       (res)
	);

endmodule
`default_nettype wire

/* design/dcf_checker.sv */
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// dcf_checker: port-level checks of the directed cycle finder
// Watches the top-level ports; bound to every top-level instance.
// ----------------------------------------------------------------------------
module dcf_checker
	import dcf_pkg::*;
(
	input wire logic clk,
	input wire logic arst_n,
	input wire logic start,
	input wire logic busy,
	input wire logic res_valid,
	input wire res_t res,
	input wire logic cfg_ready
);

	// an accepted request either keeps the block busy or answers at once
	a_req_answered: assert property (@(posedge clk) disable iff (!arst_n)
		start && !busy |=> busy || res_valid)
		else $error("request neither answered nor in progress");

	// more results follow a non-final one
	a_more_follow: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid && !res.last |=> res_valid)
		else $error("cycle report broken off");

	// only cycle reports span several results
	a_single_plain: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid && !res.has_cycle |-> res.last)
		else $error("plain result without last");

	a_cfg_idle: assert property (@(posedge clk) disable iff (!arst_n)
		!busy |-> cfg_ready)
		else $error("config refused while idle");

endmodule

bind directed_cycle_finder_top dcf_checker u_dcf_checker (
	.clk       (clk),
	.arst_n    (arst_n),
	.start     (start),
	.busy      (busy),
	.res_valid (res_valid),
	.res       (res),
	.cfg_ready (cfg_ready)
);
`default_nettype wire
